// ----- design/pidc_pkg.sv -----
// Shared types, register codes and constants of the clamped-integral PID controller.
package pidc_pkg;

	localparam int DATA_W  = 16;
	localparam int INTEG_W = 18;
	localparam int ACC_W   = 32;
	localparam int SHIFT_W = 5;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef logic signed [DATA_W-1:0]  data_t;
	typedef logic signed [INTEG_W-1:0] integ_t;
	typedef logic        [DATA_W-1:0]  gain_t;
	typedef logic        [ACC_W-1:0]   acc_t;
	typedef logic        [SHIFT_W-1:0] shift_t;

	// Anti-windup bound of the integral
	localparam integ_t INTEG_LIMIT = 18'sd65535;

	// Register reset values
	localparam shift_t OUT_SHIFT_RST = 5'd15;
	localparam data_t  OUT_MAX_RST   = 16'sh7FFF;
	localparam data_t  OUT_MIN_RST   = 16'sh8000;

	// Register index (byte address / 4)
	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_OUT_SHIFT = 3'd3,
		REG_OUT_MAX   = 3'd4,
		REG_OUT_MIN   = 3'd5
	} pidc_reg_t;

	typedef struct packed {
		gain_t  gain_p;
		gain_t  gain_i;
		gain_t  gain_d;
		shift_t out_shift;
		data_t  out_max;
		data_t  out_min;
	} pidc_cfg_t;

	// Error terms handed from the error stage to the multiply stage
	typedef struct packed {
		data_t  err;
		integ_t integ;
		data_t  deriv;
	} pidc_terms_t;

	// Wrapped products handed from the multiply stage to the output stage
	typedef struct packed {
		acc_t p_term;
		acc_t i_term;
		acc_t d_term;
	} pidc_prod_t;

endpackage

// ----- design/pidc_if.sv -----
// Valid/ready channel interfaces for samples and drive results.
interface pidc_sample_if;
	logic           valid;
	logic           ready;
	pidc_pkg::data_t measured;
	pidc_pkg::data_t setpoint;

	modport source (output valid, measured, setpoint, input ready);
	modport sink (input valid, measured, setpoint, output ready);
endinterface

interface pidc_result_if;
	logic           valid;
	logic           ready;
	pidc_pkg::data_t drive;

	modport source (output valid, drive, input ready);
	modport sink (input valid, drive, output ready);
endinterface

// ----- design/pidc_cfg.sv -----
// APB-style configuration register bank.
module pidc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pidc_pkg::PADDR_W-1:0]   paddr,
	input  logic [pidc_pkg::PDATA_W-1:0]   pwdata,
	output logic [pidc_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output pidc_pkg::pidc_cfg_t            cfg
);
	import pidc_pkg::*;

	pidc_cfg_t cfg_q;
	pidc_reg_t reg_sel;
	logic      wr_en;

	assign pready  = 1'b1;
	assign reg_sel = pidc_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.out_shift <= OUT_SHIFT_RST;
			cfg_q.out_max   <= OUT_MAX_RST;
			cfg_q.out_min   <= OUT_MIN_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_GAIN_P:    cfg_q.gain_p    <= pwdata[DATA_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i    <= pwdata[DATA_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d    <= pwdata[DATA_W-1:0];
				REG_OUT_SHIFT: cfg_q.out_shift <= pwdata[SHIFT_W-1:0];
				REG_OUT_MAX:   cfg_q.out_max   <= data_t'(pwdata[DATA_W-1:0]);
				REG_OUT_MIN:   cfg_q.out_min   <= data_t'(pwdata[DATA_W-1:0]);
				default: ;
			endcase
		end
	end

	// Read back; signed limits come back sign-extended
	always_comb begin
		case (reg_sel)
			REG_GAIN_P:    prdata = PDATA_W'(cfg_q.gain_p);
			REG_GAIN_I:    prdata = PDATA_W'(cfg_q.gain_i);
			REG_GAIN_D:    prdata = PDATA_W'(cfg_q.gain_d);
			REG_OUT_SHIFT: prdata = PDATA_W'(cfg_q.out_shift);
			REG_OUT_MAX:   prdata = PDATA_W'(cfg_q.out_max);
			REG_OUT_MIN:   prdata = PDATA_W'(cfg_q.out_min);
			default:       prdata = '0;
		endcase
	end

endmodule

// ----- design/pidc_err.sv -----
// Input register and error stage: error, clamped integral, derivative and controller state.
module pidc_err (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pidc_pkg::data_t       measured,
	input  pidc_pkg::data_t       setpoint,
	output logic                  vld_s2,
	input  logic                  rdy_s3,
	output pidc_pkg::pidc_terms_t terms_s2
);
	import pidc_pkg::*;

	logic   vld_s1;
	data_t  measured_s1;
	data_t  setpoint_s1;
	logic   rdy_s1;
	logic   rdy_s2;
	logic   adv_s1;
	integ_t error_sum_q;
	data_t  last_error_q;
	data_t  err_c;
	integ_t integ_raw;
	integ_t integ_c;
	data_t  deriv_c;

	// A stage takes new data when empty or when its content moves on
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign adv_s1   = vld_s1 && rdy_s2;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			measured_s1 <= measured;
			setpoint_s1 <= setpoint;
		end
	end

	// Wrapped error, clamped integral, wrapped derivative
	always_comb begin
		err_c     = setpoint_s1 - measured_s1;
		integ_raw = error_sum_q + INTEG_W'(err_c);
		if (integ_raw > INTEG_LIMIT) begin
			integ_c = INTEG_LIMIT;
		end else if (integ_raw < -INTEG_LIMIT) begin
			integ_c = -INTEG_LIMIT;
		end else begin
			integ_c = integ_raw;
		end
		deriv_c = err_c - last_error_q;
	end

	// Advance the controller state once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
			vld_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				error_sum_q  <= integ_c;
				last_error_q <= err_c;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			terms_s2 <= '{err: err_c, integ: integ_c, deriv: deriv_c};
		end
	end

	// Integral never leaves the anti-windup range
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(error_sum_q <= INTEG_LIMIT) && (error_sum_q >= -INTEG_LIMIT))
		else $error("integral outside anti-windup range");

	// State and stage-2 terms agree after an advance
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (terms_s2.err == last_error_q) && (terms_s2.integ == error_sum_q))
		else $error("controller state does not match forwarded terms");

	// A stalled transaction leaves the state untouched
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !rdy_s2) |=> ($stable(error_sum_q) && $stable(last_error_q)))
		else $error("controller state changed while stalled");

endmodule

// ----- design/pidc_mac.sv -----
// Multiply stage: three gain products, each wrapped to 32 bits.
module pidc_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_s2,
	output logic                  rdy_s3,
	input  pidc_pkg::pidc_terms_t terms_s2,
	input  pidc_pkg::pidc_cfg_t   cfg,
	output logic                  vld_s3,
	input  logic                  rdy_o,
	output pidc_pkg::pidc_prod_t  prod_s3
);
	import pidc_pkg::*;

	logic signed [DATA_W+DATA_W:0]  p_full;
	logic signed [INTEG_W+DATA_W:0] i_full;
	logic signed [DATA_W+DATA_W:0]  d_full;

	assign rdy_s3 = !vld_s3 || rdy_o;

	// Signed term times unsigned gain; the low 32 bits are the wrapped product
	always_comb begin
		p_full = terms_s2.err * $signed({1'b0, cfg.gain_p});
		i_full = terms_s2.integ * $signed({1'b0, cfg.gain_i});
		d_full = terms_s2.deriv * $signed({1'b0, cfg.gain_d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			prod_s3.p_term <= p_full[ACC_W-1:0];
			prod_s3.i_term <= i_full[ACC_W-1:0];
			prod_s3.d_term <= d_full[ACC_W-1:0];
		end
	end

endmodule

// ----- design/pidc_sat.sv -----
// Output stage: wrapped sum, arithmetic scaling shift, saturation and result register.
module pidc_sat (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_s3,
	output logic                 rdy_o,
	input  pidc_pkg::pidc_prod_t prod_s3,
	input  pidc_pkg::pidc_cfg_t  cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pidc_pkg::data_t      drive
);
	import pidc_pkg::*;

	logic               out_valid_q;
	data_t              drive_q;
	acc_t               sum_c;
	logic signed [ACC_W-1:0] scaled_c;
	logic signed [ACC_W-1:0] max_c;
	logic signed [ACC_W-1:0] min_c;
	data_t              drive_c;

	assign rdy_o     = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// Sum modulo 2^32, shift, then clamp with the upper limit checked first
	always_comb begin
		sum_c    = prod_s3.p_term + prod_s3.i_term + prod_s3.d_term;
		scaled_c = $signed(sum_c) >>> cfg.out_shift;
		max_c    = ACC_W'(cfg.out_max);
		min_c    = ACC_W'(cfg.out_min);
		if (scaled_c > max_c) begin
			drive_c = cfg.out_max;
		end else if (scaled_c < min_c) begin
			drive_c = cfg.out_min;
		end else begin
			drive_c = scaled_c[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_s3) begin
			drive_q <= drive_c;
		end
	end

endmodule

// ----- design/pid_controller_clamped_integral_top.sv -----
// Top level of the clamped-integral PID controller.
//
//   channel   kind           handshake        payload
//   sample    input stream   valid / ready    measured[15:0], setpoint[15:0]
//   result    output stream  valid / ready    drive[15:0]
//   apb       register port  psel / penable   paddr[4:0], pwdata / prdata[31:0]
//
// One sample is taken per cycle unless the pipeline backs up to the input; a drive
// value passes the input register, error stage, multiply stage and output register
// after its sample is taken. The integral/previous-error update in the error stage
// is the loop that sets this rate. Reset clears the integral and previous error and
// loads register defaults. Each stage holds its transaction while the next is full;
// empty stages keep filling, so samples are still taken while a result waits.
module pid_controller_clamped_integral_top (
	input  logic                         clk,
	input  logic                         arst_n,
	pidc_sample_if.sink                  sample,
	pidc_result_if.source                result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pidc_pkg::PADDR_W-1:0] paddr,
	input  logic [pidc_pkg::PDATA_W-1:0] pwdata,
	output logic [pidc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import pidc_pkg::*;

	pidc_cfg_t   cfg;
	logic        vld_s2;
	pidc_terms_t terms_s2;
	logic        rdy_s3;
	logic        vld_s3;
	pidc_prod_t  prod_s3;
	logic        rdy_o;

	pidc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidc_err u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.measured (sample.measured),
		.setpoint (sample.setpoint),
		.vld_s2   (vld_s2),
		.rdy_s3   (rdy_s3),
		.terms_s2 (terms_s2)
	);

	pidc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s2   (vld_s2),
		.rdy_s3   (rdy_s3),
		.terms_s2 (terms_s2),
		.cfg      (cfg),
		.vld_s3   (vld_s3),
		.rdy_o    (rdy_o),
		.prod_s3  (prod_s3)
	);

	pidc_sat u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s3    (vld_s3),
		.rdy_o     (rdy_o),
		.prod_s3   (prod_s3),
		.cfg       (cfg),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.drive     (result.drive)
	);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the clamped-integral PID controller top level.
`timescale 1ns / 100ps

module testbench;
	import pidc_pkg::*;

	// Register indexes outside the map; writes there must be ignored
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int DRIVE_LATENCY = 4;
	localparam int PRINT_LIMIT = 40;

	// Tracks controller state, predicts each drive value and checks results in order
	class drive_checker;
		gain_t  kp, ki, kd;
		shift_t shift_amt;
		data_t  drive_hi, drive_lo;
		int     integral;
		data_t  prev_error;
		data_t  pending_drive[$];
		int     mismatch_count;

		function new();
			kp = '0;
			ki = '0;
			kd = '0;
			shift_amt = OUT_SHIFT_RST;
			drive_hi = OUT_MAX_RST;
			drive_lo = OUT_MIN_RST;
			integral = 0;
			prev_error = '0;
			mismatch_count = 0;
		endfunction

		task report(string msg);
			if (mismatch_count < PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, msg);
			mismatch_count++;
		endtask

		function void write_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_GAIN_P:    kp = value[15:0];
				REG_GAIN_I:    ki = value[15:0];
				REG_GAIN_D:    kd = value[15:0];
				REG_OUT_SHIFT: shift_amt = value[4:0];
				REG_OUT_MAX:   drive_hi = value[15:0];
				REG_OUT_MIN:   drive_lo = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_GAIN_P:    return {16'b0, kp};
				REG_GAIN_I:    return {16'b0, ki};
				REG_GAIN_D:    return {16'b0, kd};
				REG_OUT_SHIFT: return {27'b0, shift_amt};
				REG_OUT_MAX:   return {16'b0, drive_hi};
				REG_OUT_MIN:   return {16'b0, drive_lo};
				default:       return '0;
			endcase
		endfunction

		function logic [31:0] reg_mask(logic [2:0] idx);
			return (idx == REG_OUT_SHIFT) ? 32'h1F : 32'hFFFF;
		endfunction

		// Advance integral and previous error, then form the clamped drive
		function data_t next_drive(data_t meas, data_t target);
			data_t err, deriv;
			int acc, limit;
			acc_t total;
			logic signed [31:0] scaled;
			limit = int'(INTEG_LIMIT);
			err = target - meas;
			acc = integral + err;
			if (acc > limit)
				acc = limit;
			if (acc < -limit)
				acc = -limit;
			deriv = err - prev_error;
			integral = acc;
			prev_error = err;
			total = acc_t'(longint'(err) * longint'(kp))
				+ acc_t'(longint'(acc) * longint'(ki))
				+ acc_t'(longint'(deriv) * longint'(kd));
			scaled = $signed(total) >>> shift_amt;
			if (scaled > drive_hi)
				return drive_hi;
			else if (scaled < drive_lo)
				return drive_lo;
			return data_t'(scaled);
		endfunction

		function void take_sample(data_t meas, data_t target);
			pending_drive.push_back(next_drive(meas, target));
		endfunction

		task check_drive(data_t got);
			data_t want;
			if (pending_drive.size() == 0) begin
				report($sformatf("drive %0d with no sample outstanding", got));
			end else begin
				want = pending_drive.pop_front();
				if (got !== want)
					report($sformatf("drive %0d, predicted %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	pidc_sample_if sample_bus ();
	pidc_result_if result_bus ();

	drive_checker chk = new();

	// Idling controls for the sample and drive sides
	bit quiet;
	int tx_pct;
	int rx_pct;
	int rx_hold;
	int rx_gap;

	pid_controller_clamped_integral_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the run hangs
	initial begin
		#4_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// Drive side: ready with random stall bursts and an occasional long hold-off
	initial begin
		result_bus.ready = 1'b0;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				result_bus.ready <= 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				result_bus.ready <= 1'b0;
				rx_gap--;
			end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
				rx_gap = $urandom_range(1, 19) - 1;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// Check every drive transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			chk.check_drive(result_bus.drive);
	end

	task apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr)
			chk.write_register(idx, wdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task check_register(logic [2:0] idx);
		logic [31:0] rd;
		apb_access(1'b0, idx, 32'b0, rd);
		if (((rd ^ chk.reg_value(idx)) & chk.reg_mask(idx)) !== 32'b0)
			chk.report($sformatf("register %0d reads %h, expected %h", idx, rd,
				chk.reg_value(idx)));
	endtask

	// Write every register, read each back, then poke an unmapped index
	task configure(gain_t gp, gain_t gi, gain_t gd, shift_t sh, data_t hi, data_t lo);
		logic [31:0] vals[6];
		logic [31:0] rd;
		vals = '{{16'b0, gp}, {16'b0, gi}, {16'b0, gd}, {27'b0, sh},
			{{16{hi[15]}}, hi}, {{16{lo[15]}}, lo}};
		for (int i = REG_GAIN_P; i <= REG_OUT_MIN; i++) begin
			apb_access(1'b1, 3'(i), vals[i], rd);
			check_register(3'(i));
		end
		apb_access(1'b1, 3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom, rd);
	endtask

	function gain_t pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return gain_t'($urandom_range(0, 255));
			default: return gain_t'($urandom);
		endcase
	endfunction

	function data_t pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return data_t'($urandom);
		endcase
	endfunction

	task random_configure;
		shift_t sh;
		data_t hi, lo, tmp;
		case ($urandom_range(0, 4))
			0: sh = '0;
			1: sh = '1;
			default: sh = shift_t'($urandom_range(8, 24));
		endcase
		hi = pick_value();
		lo = pick_value();
		// Mostly ordered limits, sometimes crossed
		if ($urandom_range(0, 5) != 0 && lo > hi) begin
			tmp = lo;
			lo = hi;
			hi = tmp;
		end
		configure(pick_gain(), pick_gain(), pick_gain(), sh, hi, lo);
	endtask

	// Offer one sample, hold it until taken, then maybe idle
	task send_sample(data_t meas, data_t target);
		sample_bus.valid <= 1'b1;
		sample_bus.measured <= meas;
		sample_bus.setpoint <= target;
		do @(posedge clk); while (!sample_bus.ready);
		chk.take_sample(meas, target);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < tx_pct) begin
			sample_bus.valid <= 1'b0;
			sample_bus.measured <= data_t'($urandom);
			sample_bus.setpoint <= data_t'($urandom);
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every drive value has come back
	task drain;
		sample_bus.valid <= 1'b0;
		while (chk.pending_drive.size() != 0)
			@(posedge clk);
		repeat (DRIVE_LATENCY) @(negedge clk);
	endtask

	// Runs of random samples, slow tracking, or a steady large error
	task run_phase(int count, int tx, int rx);
		int mode, run_left;
		data_t anchor, push, meas, target;
		tx_pct = tx;
		rx_pct = rx;
		run_left = 0;
		mode = 0;
		anchor = '0;
		push = '0;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				mode = $urandom_range(0, 2);
				run_left = $urandom_range(1, 24);
				anchor = pick_value();
				push = data_t'($urandom_range(4000, 32767));
				if ($urandom_range(0, 1))
					push = -push;
			end
			run_left--;
			case (mode)
				0: begin
					meas = pick_value();
					target = pick_value();
				end
				1: begin
					target = anchor;
					meas = anchor + data_t'($urandom_range(0, 64)) - 16'sd32;
				end
				default: begin
					target = anchor;
					meas = anchor - push;
				end
			endcase
			send_sample(meas, target);
		end
		drain();
	endtask

	initial begin
		int dir_meas[14];
		int dir_target[14];
		dir_meas = '{0, -32768, 32767, 0, -1, -32768, -32768, -32768, -32768,
			0, 0, 0, 0, 32767};
		dir_target = '{0, 32767, -32768, 32767, 32767, 0, 0, 0, 0,
			32767, 32767, 32767, 32767, 32767};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_bus.valid = 1'b0;
		sample_bus.measured = '0;
		sample_bus.setpoint = '0;
		quiet = 1'b0;
		tx_pct = 0;
		rx_pct = 0;
		rx_hold = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values of every register
		for (int i = REG_GAIN_P; i <= REG_OUT_MIN; i++)
			check_register(3'(i));

		// Zero gains out of reset give a zero drive
		for (int i = 0; i < 3; i++)
			send_sample(pick_value(), pick_value());
		drain();

		// Error and derivative wrap, integral driven into its lower clamp
		configure(16'd3, 16'd2, 16'd1, 5'd0, 16'sh7FFF, 16'sh8000);
		tx_pct = 20;
		rx_pct = 20;
		for (int i = 0; i < 14; i++)
			send_sample(data_t'(dir_meas[i]), data_t'(dir_target[i]));
		drain();

		// Full gains on an integral near its upper bound wrap the 32-bit sum
		configure('1, '1, '1, 5'd0, 16'sh7FFF, 16'sh8000);
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh8000, 16'sh7FFF);
		drain();
		configure('1, '1, '1, 5'd31, 16'sh7FFF, 16'sh8000);
		send_sample(16'sh7FFF, 16'sh8000);
		send_sample(16'sh0000, 16'sh0000);
		drain();

		// Crossed limits: upper limit below lower limit
		configure(16'd500, 16'd0, 16'd0, 5'd4, -16'sd100, 16'sd100);
		send_sample(16'sd0, 16'sd1000);
		send_sample(16'sd1000, 16'sd0);
		send_sample(16'sd0, 16'sd0);
		drain();

		// Random phases; one holds off the drive side so the pipeline backs up
		for (int p = 0; p < 6; p++) begin
			random_configure();
			if (p == 2) begin
				rx_hold = 150;
				run_phase(95, 0, 30);
			end else if (p % 3 == 0) begin
				run_phase(95, 0, 0);
			end else begin
				run_phase(95, 25, 30);
			end
		end

		// Last stretch with both sides running flat out
		quiet = 1'b1;
		random_configure();
		run_phase(80, 0, 0);

		if (chk.mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
